// ----- src/lzt_pkg.sv -----
// Shared constants and controller/datapath handshake types for the LZ77 tokenizer.
`default_nettype none
package lzt_pkg;
  localparam int WINDOW_MAX = 1024;
  localparam int LOOKAHEAD_MAX = 16;
  localparam int HADDR_W = $clog2(WINDOW_MAX);
  localparam int WIN_W = 11;
  localparam int LA_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 2'd1;

  localparam logic [WIN_W-1:0] WIN_RESET = 11'd1024;
  localparam logic [LA_W-1:0] LA_RESET = 5'd16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic srch_init;
    logic cmp_step;
    logic emit;
    logic commit;
    logic clear;
  } lzt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_token;
    logic last_pend;
    logic avail_zero;
    logic step_cont;
    logic d_one;
    logic out_busy;
    logic rem_one;
  } lzt_stat_t;
endpackage
`default_nettype wire

// ----- src/lzt_in_if.sv -----
// Input byte channel.
`default_nettype none
interface lzt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- src/lzt_out_if.sv -----
// Output token channel.
`default_nettype none
interface lzt_out_if;
  logic       valid;
  logic       ready;
  logic       is_match;
  logic [7:0] literal;
  logic [9:0] distance;
  logic [3:0] match_length;
  logic       last_token;
  modport source (output valid, output is_match, output literal, output distance,
                  output match_length, output last_token, input ready);
  modport sink (input valid, input is_match, input literal, input distance,
                input match_length, input last_token, output ready);
endinterface
`default_nettype wire

// ----- src/lzt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/lzt_ctrl.sv -----
// Sequencer: input intake, window search, token emit and history commit.
`default_nettype none
module lzt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lzt_pkg::lzt_stat_t stat,
  output lzt_pkg::lzt_cmd_t      cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_START, S_RD, S_CMP, S_EMIT, S_COMMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (in_valid) state <= S_EVAL;
        S_EVAL: begin
          if (stat.need_token) state <= S_START;
          else state <= S_IDLE;
        end
        S_START:  state <= stat.avail_zero ? S_EMIT : S_RD;
        S_RD:     state <= S_CMP;
        S_CMP: begin
          if (stat.step_cont || !stat.d_one) state <= S_RD;
          else state <= S_EMIT;
        end
        S_EMIT:   if (!stat.out_busy) state <= S_COMMIT;
        S_COMMIT: if (stat.rem_one) state <= S_EVAL;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd = '0;
    in_ready = (state == S_IDLE);
    cmd.load_in = (state == S_IDLE) && in_valid;
    cmd.srch_init = (state == S_START);
    cmd.cmp_step = (state == S_CMP);
    cmd.emit = (state == S_EMIT) && !stat.out_busy;
    cmd.commit = (state == S_COMMIT);
    cmd.clear = (state == S_EVAL) && !stat.need_token && stat.last_pend;
  end
endmodule
`default_nettype wire

// ----- src/lzt_datapath.sv -----
// Lookahead buffer, history window, search counters and token register.
`default_nettype none
module lzt_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lzt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lzt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [7:0]                       in_byte,
  input  wire logic                             in_last,
  input  wire lzt_pkg::lzt_cmd_t                cmd,
  output lzt_pkg::lzt_stat_t                    stat,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_is_match,
  output logic [7:0]                            out_literal,
  output logic [9:0]                            out_distance,
  output logic [3:0]                            out_length,
  output logic                                  out_last
);
  localparam int HW = lzt_pkg::HADDR_W;

  logic [lzt_pkg::WIN_W-1:0] win_reg;
  logic [lzt_pkg::LA_W-1:0]  la_reg;
  logic [7:0]                la [lzt_pkg::LOOKAHEAD_MAX];
  logic [4:0]                count;
  logic [HW-1:0]             wp;
  logic [HW:0]               fill;
  logic                      last_flag;
  logic [HW-1:0]             d;
  logic [3:0]                k;
  logic [3:0]                best;
  logic [HW-1:0]             best_d;
  logic [3:0]                rem;

  logic [lzt_pkg::WIN_W-1:0] weff;
  logic [lzt_pkg::LA_W-1:0]  leff;
  logic [4:0]                maxla;
  logic [4:0]                maxlen;
  logic [HW:0]               avail;
  logic [4:0]                k_inc;
  logic [4:0]                len;
  logic                      eq;
  logic [7:0]                ram_q;
  logic [HW-1:0]             raddr;

  // Clamped register values
  always_comb begin
    weff = win_reg;
    if (win_reg < 11'd2) weff = 11'd2;
    else if (win_reg > 11'(lzt_pkg::WINDOW_MAX)) weff = 11'(lzt_pkg::WINDOW_MAX);
    leff = la_reg;
    if (la_reg < 5'd3) leff = 5'd3;
    else if (la_reg > 5'(lzt_pkg::LOOKAHEAD_MAX)) leff = 5'(lzt_pkg::LOOKAHEAD_MAX);
    maxla = leff - 5'd1;
    maxlen = (maxla > count) ? count : maxla;
    avail = ((weff - 11'd1) > fill) ? fill : (weff - 11'd1);
  end

  // Compare step
  assign raddr = wp - d + {{(HW-4){1'b0}}, k};
  assign eq = (ram_q == la[k]);
  assign k_inc = {1'b0, k} + 5'd1;
  assign len = eq ? k_inc : {1'b0, k};

  always_comb begin
    stat.need_token = (count != 5'd0) && (last_flag || count >= maxla);
    stat.last_pend = last_flag;
    stat.avail_zero = (avail == '0);
    stat.step_cont = eq && (k_inc < maxlen) && ({{(HW-5){1'b0}}, k_inc} < d);
    stat.d_one = (d == {{(HW-1){1'b0}}, 1'b1});
    stat.out_busy = out_valid;
    stat.rem_one = (rem == 4'd1);
  end

  lzt_ram #(.WIDTH(8), .DEPTH(lzt_pkg::WINDOW_MAX)) u_hist (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wp),
    .wdata (la[0]),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= lzt_pkg::WIN_RESET;
      la_reg <= lzt_pkg::LA_RESET;
      count <= '0;
      wp <= '0;
      fill <= '0;
      last_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == lzt_pkg::REG_WINDOW) win_reg <= cfg_wdata;
      if (cfg_we && cfg_index == lzt_pkg::REG_LOOKAHEAD) la_reg <= cfg_wdata[4:0];
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.emit) out_valid <= 1'b1;
      if (cmd.load_in) begin
        last_flag <= in_last;
        if (count < 5'(lzt_pkg::LOOKAHEAD_MAX)) count <= count + 5'd1;
      end
      if (cmd.commit) begin
        count <= count - 5'd1;
        wp <= wp + {{(HW-1){1'b0}}, 1'b1};
        if (fill < (HW+1)'(lzt_pkg::WINDOW_MAX)) fill <= fill + {{HW{1'b0}}, 1'b1};
      end
      if (cmd.clear) begin
        fill <= '0;
        wp <= '0;
        last_flag <= 1'b0;
      end
    end
  end

  // Payload: lookahead bytes, search state, token word
  always_ff @(posedge clk) begin
    if (cmd.load_in && count < 5'(lzt_pkg::LOOKAHEAD_MAX)) la[count[3:0]] <= in_byte;
    if (cmd.commit) begin
      for (int i = 0; i < lzt_pkg::LOOKAHEAD_MAX - 1; i++) la[i] <= la[i+1];
      rem <= rem - 4'd1;
    end
    if (cmd.srch_init) begin
      d <= avail[HW-1:0];
      k <= '0;
      best <= 4'd1;
      best_d <= '0;
    end
    if (cmd.cmp_step) begin
      if (stat.step_cont) begin
        k <= k_inc[3:0];
      end else begin
        if (len > {1'b0, best}) begin
          best <= len[3:0];
          best_d <= d;
        end
        d <= d - {{(HW-1){1'b0}}, 1'b1};
        k <= '0;
      end
    end
    if (cmd.emit) begin
      rem <= best;
      out_is_match <= (best > 4'd1);
      out_literal <= (best > 4'd1) ? 8'd0 : la[0];
      out_distance <= (best > 4'd1) ? best_d : '0;
      out_length <= (best > 4'd1) ? best : 4'd0;
      out_last <= last_flag && (count == {1'b0, best});
    end
  end
endmodule
`default_nettype wire

// ----- src/lz77_sliding_window_tokenizer.sv -----
// LZ77 tokenizer top level: brute-force window search over a 1024-byte history RAM.
// Per token: evaluate, start the search, then a read state and a compare state per byte compare,
//   then emit, then a commit state that shifts each byte of the token into the history.
// Compares go through the single history read port, one at a time.
// Input bytes are taken one at a time, only while no token is in progress.
// Reset (rst, synchronous) empties the lookahead and history and restores
//   window_size 1024, lookahead_size 16; history RAM contents are not cleared.
`default_nettype none
module lz77_sliding_window_tokenizer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lzt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lzt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lzt_in_if.sink                              bytes,
  lzt_out_if.source                           tokens
);
  lzt_pkg::lzt_cmd_t  cmd;
  lzt_pkg::lzt_stat_t stat;

  lzt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_ready (bytes.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_byte      (bytes.data_byte),
    .in_last      (bytes.last_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (tokens.valid),
    .out_ready    (tokens.ready),
    .out_is_match (tokens.is_match),
    .out_literal  (tokens.literal),
    .out_distance (tokens.distance),
    .out_length   (tokens.match_length),
    .out_last     (tokens.last_token)
  );
endmodule
`default_nettype wire

// ----- src/lzt_checker.sv -----
// Port-level checks on the token stream, bound to the top level.
`default_nettype none
module lzt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       is_match,
  input wire logic [7:0] literal,
  input wire logic [9:0] distance,
  input wire logic [3:0] match_length
);
  // Token valid holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("token dropped while stalled");

  // Matches are at least two bytes and point backward
  a_match_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_match |-> match_length >= 4'd2 && distance != 10'd0)
    else $error("bad match token");

  // A match never reaches past the current position and carries a zero literal
  a_match_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_match |-> {6'd0, match_length} <= distance && literal == 8'd0)
    else $error("match overlaps current position");

  // Literals carry no distance or length
  a_literal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_match |-> distance == 10'd0 && match_length == 4'd0)
    else $error("literal with match fields");
endmodule

bind lz77_sliding_window_tokenizer lzt_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tokens.valid),
  .out_ready    (tokens.ready),
  .is_match     (tokens.is_match),
  .literal      (tokens.literal),
  .distance     (tokens.distance),
  .match_length (tokens.match_length)
);
`default_nettype wire
